// File: hw/rtl/plps_pkg.sv
// Shared types, codes and constants for the power LED pattern sequencer.
`default_nettype none

package plps_pkg;

    // Longest pattern a sequence may run; longer lengths are clamped to it.
    localparam int MAX_PATTERN_STEPS = 16;
    localparam int POS_W             = $clog2(MAX_PATTERN_STEPS + 1);

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSP_PAT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSP_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_PAT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_LEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_PAT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_LEN     = 3'd7;

    // Commands.
    localparam logic [3:0] CMD_TICK      = 4'd0;
    localparam logic [3:0] CMD_SUSPEND   = 4'd1;
    localparam logic [3:0] CMD_SHUTDOWN  = 4'd2;
    localparam logic [3:0] CMD_RESUME    = 4'd3;
    localparam logic [3:0] CMD_ALERT_ON  = 4'd4;
    localparam logic [3:0] CMD_ALERT_OFF = 4'd5;
    localparam logic [3:0] CMD_CRITICAL  = 4'd6;
    localparam logic [3:0] CMD_SET_LEVEL = 4'd7;
    localparam logic [3:0] CMD_TOGGLE    = 4'd8;

    // Power states carried with alert off.
    localparam logic [1:0] PS_ON      = 2'd0;
    localparam logic [1:0] PS_SUSPEND = 2'd1;
    localparam logic [1:0] PS_OFF     = 2'd2;

    // Pattern kinds.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_SUSPEND  = 2'd1;
    localparam logic [1:0] KIND_ALERT    = 2'd2;
    localparam logic [1:0] KIND_CRITICAL = 2'd3;

    // Delayed actions.
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_SUSPEND  = 2'd1;
    localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

    typedef struct packed {
        logic [3:0] command;
        logic       level;
        logic [1:0] power_state;
    } t_in_beat;

    typedef struct packed {
        logic led_lit;
        logic pattern_running;
        logic delay_pending;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] blink_period_ticks;
        logic [15:0] off_delay_ticks;
        logic [15:0] suspend_pattern;
        logic [4:0]  suspend_length;
        logic [15:0] alert_pattern;
        logic [4:0]  alert_length;
        logic [15:0] critical_pattern;
        logic [4:0]  critical_length;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/plps_cfg.sv
// Configuration register file with write-only access.
`default_nettype none

module plps_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [plps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [plps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output plps_pkg::t_cfg                          o_cfg
);

    plps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_period_ticks <= 16'd500;
            r_cfg.off_delay_ticks    <= 16'd2000;
            r_cfg.suspend_pattern    <= 16'd3;
            r_cfg.suspend_length     <= 5'd8;
            r_cfg.alert_pattern      <= 16'd1;
            r_cfg.alert_length       <= 5'd2;
            r_cfg.critical_pattern   <= 16'd347;
            r_cfg.critical_length    <= 5'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plps_pkg::REG_BLINK_PERIOD: r_cfg.blink_period_ticks <= i_cfg_data;
                plps_pkg::REG_OFF_DELAY:    r_cfg.off_delay_ticks    <= i_cfg_data;
                plps_pkg::REG_SUSP_PAT:     r_cfg.suspend_pattern    <= i_cfg_data;
                plps_pkg::REG_SUSP_LEN:     r_cfg.suspend_length     <= i_cfg_data[4:0];
                plps_pkg::REG_ALERT_PAT:    r_cfg.alert_pattern      <= i_cfg_data;
                plps_pkg::REG_ALERT_LEN:    r_cfg.alert_length       <= i_cfg_data[4:0];
                plps_pkg::REG_CRIT_PAT:     r_cfg.critical_pattern   <= i_cfg_data;
                plps_pkg::REG_CRIT_LEN:     r_cfg.critical_length    <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/plps_core.sv
// Sequencer state and the one-beat event update.
`default_nettype none

module plps_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire plps_pkg::t_in_beat  i_beat,
    input  wire plps_pkg::t_cfg      i_cfg,
    output plps_pkg::t_out_beat      o_result
);

    typedef struct packed {
        logic                       led;
        logic                       auto_on;
        logic [1:0]                 kind;
        logic [plps_pkg::POS_W-1:0] pos;
        logic                       running;
        logic [15:0]                blink_cnt;
        logic [1:0]                 action;
        logic [15:0]                delay_cnt;
    } t_st;

    t_st r_st;
    t_st n_st;

    // One pattern step, then rearm the blink timer; with no pattern kind the timer stops.
    function automatic t_st blink_step(input t_st s, input plps_pkg::t_cfg cfg);
        t_st                        r;
        logic [15:0]                bits;
        logic [15:0]                shifted;
        logic [4:0]                 len_raw;
        logic [plps_pkg::POS_W-1:0] len_eff;
        logic [plps_pkg::POS_W-1:0] pos;
        r       = s;
        bits    = '0;
        len_raw = '0;
        unique case (s.kind)
            plps_pkg::KIND_SUSPEND: begin
                bits    = cfg.suspend_pattern;
                len_raw = cfg.suspend_length;
            end
            plps_pkg::KIND_ALERT: begin
                bits    = cfg.alert_pattern;
                len_raw = cfg.alert_length;
            end
            plps_pkg::KIND_CRITICAL: begin
                bits    = cfg.critical_pattern;
                len_raw = cfg.critical_length;
            end
            default: ;
        endcase
        if (len_raw == 5'd0) begin
            len_eff = plps_pkg::POS_W'(1);
        end else if (32'(len_raw) > plps_pkg::MAX_PATTERN_STEPS) begin
            len_eff = plps_pkg::POS_W'(plps_pkg::MAX_PATTERN_STEPS);
        end else begin
            len_eff = plps_pkg::POS_W'(len_raw);
        end
        pos     = (s.pos >= len_eff) ? '0 : s.pos;
        shifted = bits >> pos;
        if (s.kind == plps_pkg::KIND_NONE) begin
            r.running = 1'b0;
        end else begin
            if (s.auto_on) begin
                r.led = shifted[0];
                r.pos = pos + 1'b1;
            end else begin
                r.pos = pos;
            end
            r.running   = 1'b1;
            // zero period behaves as one tick
            r.blink_cnt = (cfg.blink_period_ticks == 16'd0) ? 16'd1 : cfg.blink_period_ticks;
        end
        return r;
    endfunction

    function automatic t_st start_pattern(input t_st s, input logic [1:0] kind,
                                          input plps_pkg::t_cfg cfg);
        t_st r;
        r      = s;
        r.kind = kind;
        r.pos  = '0;
        return blink_step(r, cfg);
    endfunction

    function automatic t_st arm_delay(input t_st s, input logic [1:0] act,
                                      input plps_pkg::t_cfg cfg);
        t_st r;
        r           = s;
        r.running   = 1'b0;
        r.action    = act;
        r.delay_cnt = cfg.off_delay_ticks;
        return r;
    endfunction

    function automatic t_st resume(input t_st s);
        t_st r;
        r         = s;
        r.running = 1'b0;
        r.action  = plps_pkg::ACT_NONE;
        if (s.auto_on) begin
            r.led = 1'b1;
        end
        return r;
    endfunction

    function automatic t_st tick(input t_st s, input plps_pkg::t_cfg cfg);
        t_st r;
        r = s;
        // blink timer first, then the delay timer
        if (r.running) begin
            if (r.blink_cnt <= 16'd1) begin
                r = blink_step(r, cfg);
            end else begin
                r.blink_cnt = r.blink_cnt - 16'd1;
            end
        end
        if (r.action != plps_pkg::ACT_NONE) begin
            if (r.delay_cnt <= 16'd1) begin
                r.delay_cnt = '0;
                if (r.action == plps_pkg::ACT_SUSPEND) begin
                    r.action = plps_pkg::ACT_NONE;
                    r        = start_pattern(r, plps_pkg::KIND_SUSPEND, cfg);
                end else begin
                    r.action = plps_pkg::ACT_NONE;
                    if (r.auto_on) begin
                        r.led = 1'b0;
                    end
                end
            end else begin
                r.delay_cnt = r.delay_cnt - 16'd1;
            end
        end
        return r;
    endfunction

    always_comb begin
        n_st = r_st;
        unique case (i_beat.command)
            plps_pkg::CMD_TICK:      n_st = tick(r_st, i_cfg);
            plps_pkg::CMD_SUSPEND:   n_st = arm_delay(r_st, plps_pkg::ACT_SUSPEND, i_cfg);
            plps_pkg::CMD_SHUTDOWN:  n_st = arm_delay(r_st, plps_pkg::ACT_SHUTDOWN, i_cfg);
            plps_pkg::CMD_RESUME:    n_st = resume(r_st);
            plps_pkg::CMD_ALERT_ON:  n_st = start_pattern(r_st, plps_pkg::KIND_ALERT, i_cfg);
            plps_pkg::CMD_ALERT_OFF: begin
                // replay the hook for the reported power state
                unique case (i_beat.power_state)
                    plps_pkg::PS_ON:      n_st = resume(r_st);
                    plps_pkg::PS_SUSPEND: n_st = arm_delay(r_st, plps_pkg::ACT_SUSPEND, i_cfg);
                    plps_pkg::PS_OFF:     n_st = arm_delay(r_st, plps_pkg::ACT_SHUTDOWN, i_cfg);
                    default: ;
                endcase
            end
            plps_pkg::CMD_CRITICAL:  n_st = start_pattern(r_st, plps_pkg::KIND_CRITICAL, i_cfg);
            plps_pkg::CMD_SET_LEVEL: n_st.led = i_beat.level;
            plps_pkg::CMD_TOGGLE:    n_st.auto_on = ~r_st.auto_on;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.led       <= 1'b0;
            r_st.auto_on   <= 1'b1;
            r_st.kind      <= plps_pkg::KIND_NONE;
            r_st.pos       <= '0;
            r_st.running   <= 1'b0;
            r_st.blink_cnt <= '0;
            r_st.action    <= plps_pkg::ACT_NONE;
            r_st.delay_cnt <= '0;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    assign o_result.led_lit         = n_st.led;
    assign o_result.pattern_running = n_st.running;
    assign o_result.delay_pending   = (n_st.action != plps_pkg::ACT_NONE);

endmodule

`default_nettype wire

// File: hw/rtl/power_led_pattern_sequencer_top.sv
// Top level of the power LED pattern sequencer: beat registers around the core.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | i_in_valid / o_in_stall | i_in_beat  (t_in_beat)
//  out     | out       | o_out_valid / i_out_stall| o_out_beat (t_out_beat)
//  cfg     | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One beat per cycle sustained while the output does not stall. An accepted beat
// lands in the input register; when the result register is free or draining, it
// is applied to the sequencer state and the result register takes its result.
// Reset is synchronous and active low; it loads the register defaults and the
// idle LED state. A stall on the output only backs up into the input stall when
// both registers hold a beat.
`default_nettype none

module power_led_pattern_sequencer_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire plps_pkg::t_in_beat              i_in_beat,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output plps_pkg::t_out_beat                  o_out_beat,
    input  wire logic                            i_cfg_we,
    input  wire logic [plps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [plps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    plps_pkg::t_cfg      cfg;
    plps_pkg::t_out_beat result;

    logic                r_in_valid;
    plps_pkg::t_in_beat  r_in_beat;
    logic                r_out_valid;
    plps_pkg::t_out_beat r_out_beat;

    logic fire;
    logic in_accept;

    // The held beat is applied when the result register is free or draining.
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    plps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    plps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_beat   (r_in_beat),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_beat <= i_in_beat;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the power LED pattern sequencer top level.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plps_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 11;
    // Cycles with work outstanding but no beat moving on either channel.
    localparam int IDLE_LIMIT  = 4000;
    // Drain time after the last result.
    localparam int DRAIN_WAIT  = 8;
    // Alert-off power state with no meaning; the beat is ignored.
    localparam logic [1:0] PS_NONE = 2'd3;
    localparam logic [3:0] CMD_MAX = 4'd15;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_beat             o_out_beat;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    power_led_pattern_sequencer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Beats waiting for the driver, and LED status the block owes us.
    t_in_beat  cmd_q[$];
    t_out_beat led_status_q[$];
    int        err_cnt = 0;

    // ------------------------------------------------------------------
    // Sequencer model: register shadow plus LED / timer state
    // ------------------------------------------------------------------
    logic [15:0] cfg_shadow [8];
    logic        led_level;
    logic        led_auto;
    logic [1:0]  led_kind;
    int          led_pos;
    logic        led_blink_on;
    int          led_blink_cnt;
    logic [1:0]  led_act;
    int          led_delay_cnt;

    function automatic int led_period();
        return (cfg_shadow[REG_BLINK_PERIOD] == 16'd0) ? 1 : int'(cfg_shadow[REG_BLINK_PERIOD]);
    endfunction

    function automatic void led_pattern_step();
        logic [15:0] bits;
        int          len;
        bits = '0;
        len  = 1;
        case (led_kind)
            KIND_SUSPEND: begin
                bits = cfg_shadow[REG_SUSP_PAT];
                len  = int'(cfg_shadow[REG_SUSP_LEN]);
            end
            KIND_ALERT: begin
                bits = cfg_shadow[REG_ALERT_PAT];
                len  = int'(cfg_shadow[REG_ALERT_LEN]);
            end
            KIND_CRITICAL: begin
                bits = cfg_shadow[REG_CRIT_PAT];
                len  = int'(cfg_shadow[REG_CRIT_LEN]);
            end
            default: begin
                // timer fired with nothing to show: it just stops
                led_blink_on = 1'b0;
                return;
            end
        endcase
        if (len == 0)
            len = 1;
        if (len > MAX_PATTERN_STEPS)
            len = MAX_PATTERN_STEPS;
        if (led_pos >= len)
            led_pos = 0;
        if (led_auto) begin
            led_level = (led_pos < 16) ? bits[led_pos] : 1'b0;
            led_pos   = led_pos + 1;
        end
        led_blink_on  = 1'b1;
        led_blink_cnt = led_period();
    endfunction

    function automatic void led_start(input logic [1:0] kind);
        led_kind = kind;
        led_pos  = 0;
        led_pattern_step();
    endfunction

    function automatic void led_arm(input logic [1:0] act);
        led_blink_on  = 1'b0;
        led_act       = act;
        led_delay_cnt = int'(cfg_shadow[REG_OFF_DELAY]);
    endfunction

    function automatic void led_resume();
        led_blink_on = 1'b0;
        led_act      = ACT_NONE;
        if (led_auto)
            led_level = 1'b1;
    endfunction

    function automatic void led_tick();
        logic [1:0] fired;
        // blink timer goes first on a shared tick
        if (led_blink_on) begin
            if (led_blink_cnt <= 1)
                led_pattern_step();
            else
                led_blink_cnt = led_blink_cnt - 1;
        end
        if (led_act != ACT_NONE) begin
            if (led_delay_cnt <= 1) begin
                fired         = led_act;
                led_act       = ACT_NONE;
                led_delay_cnt = 0;
                if (fired == ACT_SUSPEND)
                    led_start(KIND_SUSPEND);
                else if (led_auto)
                    led_level = 1'b0;
            end else begin
                led_delay_cnt = led_delay_cnt - 1;
            end
        end
    endfunction

    // Apply one accepted beat; returns the status the block must report.
    function automatic t_out_beat led_after_beat(input t_in_beat b);
        t_out_beat r;
        case (b.command)
            CMD_TICK:      led_tick();
            CMD_SUSPEND:   led_arm(ACT_SUSPEND);
            CMD_SHUTDOWN:  led_arm(ACT_SHUTDOWN);
            CMD_RESUME:    led_resume();
            CMD_ALERT_ON:  led_start(KIND_ALERT);
            CMD_ALERT_OFF: begin
                if (b.power_state == PS_ON)
                    led_resume();
                else if (b.power_state == PS_SUSPEND)
                    led_arm(ACT_SUSPEND);
                else if (b.power_state == PS_OFF)
                    led_arm(ACT_SHUTDOWN);
            end
            CMD_CRITICAL:  led_start(KIND_CRITICAL);
            CMD_SET_LEVEL: led_level = b.level;
            CMD_TOGGLE:    led_auto = ~led_auto;
            default: ;
        endcase
        r.led_lit         = led_level;
        r.pattern_running = led_blink_on;
        r.delay_pending   = (led_act != ACT_NONE);
        return r;
    endfunction

    function automatic void led_reset();
        cfg_shadow[REG_BLINK_PERIOD] = 16'd500;
        cfg_shadow[REG_OFF_DELAY]    = 16'd2000;
        cfg_shadow[REG_SUSP_PAT]     = 16'd3;
        cfg_shadow[REG_SUSP_LEN]     = 16'd8;
        cfg_shadow[REG_ALERT_PAT]    = 16'd1;
        cfg_shadow[REG_ALERT_LEN]    = 16'd2;
        cfg_shadow[REG_CRIT_PAT]     = 16'd347;
        cfg_shadow[REG_CRIT_LEN]     = 16'd10;
        led_level     = 1'b0;
        led_auto      = 1'b1;
        led_kind      = KIND_NONE;
        led_pos       = 0;
        led_blink_on  = 1'b0;
        led_blink_cnt = 0;
        led_act       = ACT_NONE;
        led_delay_cnt = 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps; payload held while stalled
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                led_status_q.push_back(led_after_beat(i_in_beat));
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    i_in_valid <= 1'b0;
                    gap_left   <= gap_left - 1;
                end else if (cmd_q.size() != 0) begin
                    i_in_beat  <= cmd_q.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: own stall pattern, in-order compare against the model
    // ------------------------------------------------------------------
    int stall_run;

    task automatic check_field(input string fname, input logic want_b, input logic got_b);
        if (want_b !== got_b) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, fname, want_b, got_b);
        end
    endtask

    always @(posedge i_clk) begin : mon
        t_out_beat want;
        logic      nxt;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run   <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (led_status_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result beat, expected none actual %b",
                             $time, o_out_beat);
                end else begin
                    want = led_status_q.pop_front();
                    check_field("led_lit", want.led_lit, o_out_beat.led_lit);
                    check_field("pattern_running", want.pattern_running,
                                o_out_beat.pattern_running);
                    check_field("delay_pending", want.delay_pending, o_out_beat.delay_pending);
                end
            end
            if (stall_run == 0) begin
                nxt         = ($urandom_range(0, 2) == 0);
                i_out_stall <= nxt;
                // short stall runs, free runs sometimes long enough to stream
                stall_run   <= nxt ? $urandom_range(0, 6)
                                   : (($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                                   : $urandom_range(0, 20));
            end else begin
                stall_run <= stall_run - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat moving while work is outstanding
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin : wdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (cmd_q.size() != 0 || led_status_q.size() != 0 || i_in_valid) begin
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[power_led_pattern_sequencer_top] ERROR");
                $finish;
            end
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [3:0] c, input logic lvl, input logic [1:0] ps);
        t_in_beat b;
        b.command     = c;
        b.level       = lvl;
        b.power_state = ps;
        cmd_q.push_back(b);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_cmd(CMD_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    // Sender holds off until every owed result is in and the block is quiet.
    task automatic wait_quiet();
        while (cmd_q.size() != 0 || led_status_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        // length registers keep five bits
        if (idx == REG_SUSP_LEN || idx == REG_ALERT_LEN || idx == REG_CRIT_LEN)
            cfg_shadow[idx] = data & 16'h001F;
        else
            cfg_shadow[idx] = data;
    endtask

    task automatic load_settings(input logic [15:0] per, input logic [15:0] dly,
                                 input logic [15:0] sp, input logic [15:0] sl,
                                 input logic [15:0] ap, input logic [15:0] al,
                                 input logic [15:0] cp, input logic [15:0] cl);
        cfg_write(REG_BLINK_PERIOD, per);
        cfg_write(REG_OFF_DELAY, dly);
        cfg_write(REG_SUSP_PAT, sp);
        cfg_write(REG_SUSP_LEN, sl);
        cfg_write(REG_ALERT_PAT, ap);
        cfg_write(REG_ALERT_LEN, al);
        cfg_write(REG_CRIT_PAT, cp);
        cfg_write(REG_CRIT_LEN, cl);
    endtask

    // Mostly lengths in range, now and then zero or past the clamp;
    // upper data bits are junk the register must drop.
    function automatic logic [15:0] rand_len();
        logic [15:0] v;
        v        = 16'($urandom);
        v[4:0]   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 16));
        return v;
    endfunction

    // Events each followed by a random run of ticks, at most 40 long,
    // with a little noise the block ignores.
    task automatic queue_traffic(input int n_items);
        int         done_cnt;
        int         span;
        int         pick;
        int         k;
        logic       lvl;
        logic [1:0] ps;
        done_cnt = 0;
        span     = 3 * led_period() + int'(cfg_shadow[REG_OFF_DELAY]) + 2;
        if (span > 40)
            span = 40;
        while (done_cnt < n_items) begin
            pick = $urandom_range(0, 99);
            lvl  = 1'($urandom_range(0, 1));
            ps   = 2'($urandom_range(0, 3));
            if (pick < 3) begin
                push_cmd(4'($urandom_range(int'(CMD_TOGGLE) + 1, int'(CMD_MAX))), lvl, ps);
            end else if (pick < 6) begin
                push_cmd(CMD_ALERT_OFF, lvl, PS_NONE);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    push_cmd(CMD_SUSPEND, lvl, ps);
                else if (pick < 6)
                    push_cmd(CMD_SHUTDOWN, lvl, ps);
                else if (pick < 8)
                    push_cmd(CMD_RESUME, lvl, ps);
                else if (pick < 10)
                    push_cmd(CMD_ALERT_ON, lvl, ps);
                else if (pick < 13)
                    push_cmd(CMD_ALERT_OFF, lvl, 2'($urandom_range(0, 2)));
                else if (pick < 16)
                    push_cmd(CMD_CRITICAL, lvl, ps);
                else if (pick < 19)
                    push_cmd(CMD_SET_LEVEL, lvl, ps);
                else
                    push_cmd(CMD_TOGGLE, lvl, ps);
                k = $urandom_range(0, span);
                push_ticks(k);
                done_cnt = done_cnt + 1 + k;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stim
        int ph;
        led_reset();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: long timers, only immediate effects show
        queue_traffic(20);
        wait_quiet();

        // directed walk with short timers
        load_settings(16'd2, 16'd3, 16'hA5C3, 16'd8, 16'h0001, 16'd2, 16'h015B, 16'd10);
        push_cmd(CMD_TICK, 1'b1, PS_NONE);        // nothing armed
        push_cmd(CMD_CRITICAL, 1'b0, PS_ON);      // first step at once
        push_ticks(2);                            // second step on period
        push_cmd(CMD_SUSPEND, 1'b1, PS_NONE);     // blink stops, delay armed
        push_ticks(3);                            // delay fires: suspend pattern
        push_cmd(CMD_SHUTDOWN, 1'b0, PS_SUSPEND);
        push_cmd(CMD_ALERT_ON, 1'b1, PS_OFF);     // pattern runs, delay kept
        push_ticks(3);                            // LED forced off on expiry
        push_cmd(CMD_RESUME, 1'b0, PS_OFF);
        push_cmd(CMD_ALERT_OFF, 1'b0, PS_SUSPEND);
        push_cmd(CMD_ALERT_OFF, 1'b0, PS_OFF);
        push_cmd(CMD_ALERT_OFF, 1'b0, PS_ON);
        push_cmd(CMD_ALERT_OFF, 1'b1, PS_NONE);   // ignored
        push_cmd(CMD_SET_LEVEL, 1'b0, PS_ON);
        push_cmd(CMD_TOGGLE, 1'b0, PS_ON);        // auto off
        push_cmd(CMD_CRITICAL, 1'b0, PS_ON);      // timer runs, LED frozen
        push_ticks(2);
        push_cmd(CMD_SET_LEVEL, 1'b1, PS_ON);     // manual level still taken
        push_cmd(CMD_RESUME, 1'b0, PS_ON);
        push_cmd(CMD_TOGGLE, 1'b1, PS_SUSPEND);   // auto back on
        push_cmd(4'd9, 1'b1, PS_NONE);            // unknown codes
        push_cmd(CMD_MAX, 1'b0, PS_OFF);
        wait_quiet();

        // extremes: zero timers, all-ones patterns, lengths zero and past the clamp
        load_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFE0, 16'hFFFF, 16'h001F,
                      16'hFFFF, 16'h0011);
        queue_traffic(100);
        wait_quiet();

        // extremes: longest timers, empty patterns, full and single-step lengths
        load_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'd16, 16'h0000, 16'd1,
                      16'h0000, 16'd16);
        queue_traffic(100);
        wait_quiet();

        // single-tick timers, first and last bit set, lengths 16 and above
        load_settings(16'd1, 16'd1, 16'h8001, 16'd16, 16'h8001, 16'd31,
                      16'h8001, 16'd17);
        queue_traffic(100);
        wait_quiet();

        for (ph = 0; ph < 6; ph++) begin
            load_settings(16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                          16'($urandom), rand_len(), 16'($urandom), rand_len(),
                          16'($urandom), rand_len());
            queue_traffic(75);
            if (ph == 2)
                wait_quiet();   // sender holds until the block has caught up
            queue_traffic(75);
            wait_quiet();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && led_status_q.size() == 0) begin
            $display("[power_led_pattern_sequencer_top] OK");
        end else begin
            $display("[power_led_pattern_sequencer_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/plps_pkg.sv
hw/rtl/plps_cfg.sv
hw/rtl/plps_core.sv
hw/rtl/power_led_pattern_sequencer_top.sv
sim/tb.sv
